[sv/afu_pkg.sv]
`timescale 1ns / 1ps
package afu_pkg;

    // Activation codes of the configuration register
    localparam logic [2:0] KIND_SIGMOID = 3'd0;
    localparam logic [2:0] KIND_TANH    = 3'd1;
    localparam logic [2:0] KIND_LINEAR  = 3'd2;
    localparam logic [2:0] KIND_RELU    = 3'd3;
    localparam logic [2:0] KIND_STEP    = 3'd4;

    // Operation codes of an item
    localparam logic OP_FORWARD = 1'b0;
    localparam logic OP_DERIV   = 1'b1;

    // Exponent datapath: Q0.32, value 1.0 needs one more bit
    localparam int EXP_W    = 33;
    localparam int EXP_FRAC = 32;
    // Magnitude of the exponent argument: 2*|x| needs 17 bits
    localparam int ARG_W    = 17;
    // Wide signed word for derivative products
    localparam int PROD_W   = 36;

    // Side information that travels with each item through the pipeline
    typedef struct packed {
        logic               vld;
        logic               use_exp;
        logic               is_tanh;
        logic               neg;
        logic signed [15:0] simple;
    } t_tag;

    // e^-(2^k / 2^frac) in Q0.32, worked out at elaboration
    function automatic logic [EXP_FRAC-1:0] exp_const(input int k, input int frac);
        real    r;
        longint v;
        r = $exp(-(2.0 ** (k - frac))) * (2.0 ** EXP_FRAC);
        v = longint'(r);
        if (v > 64'sd4294967295) begin
            v = 64'sd4294967295;
        end
        return v[EXP_FRAC-1:0];
    endfunction

    // Clamp to the signed 16-bit range
    function automatic logic signed [15:0] sat16(input logic signed [PROD_W-1:0] v);
        logic signed [15:0] r;
        if (v > 36'sd32767) begin
            r = 16'sh7FFF;
        end else if (v < -36'sd32768) begin
            r = 16'sh8000;
        end else begin
            r = v[15:0];
        end
        return r;
    endfunction

endpackage

[sv/afu_exp.sv]
`timescale 1ns / 1ps
module afu_exp #(
    parameter int FRAC_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [afu_pkg::ARG_W-1:0]   i_m,
    input  afu_pkg::t_tag               i_tag,
    output logic [afu_pkg::EXP_W-1:0]   o_e,
    output afu_pkg::t_tag               o_tag
);
    import afu_pkg::*;

    // One stage per argument bit: multiply by e^-(2^k/ONE) where the bit is set
    logic [EXP_W-1:0] r_e   [ARG_W];
    logic [ARG_W-1:0] r_m   [ARG_W];
    t_tag             r_tag [ARG_W];

    genvar k;
    generate
        for (k = 0; k < ARG_W; k++) begin : g_stage
            localparam logic [EXP_FRAC-1:0] C = exp_const(k, FRAC_BITS);
            logic [EXP_W-1:0]          e_in;
            logic [ARG_W-1:0]          m_in;
            t_tag                      tag_in;
            logic [EXP_W+EXP_FRAC-1:0] prod;
            logic [EXP_W-1:0]          n_e;

            if (k == 0) begin : g_first
                assign e_in   = EXP_W'(1) << EXP_FRAC;
                assign m_in   = i_m;
                assign tag_in = i_tag;
            end else begin : g_next
                assign e_in   = r_e[k-1];
                assign m_in   = r_m[k-1];
                assign tag_in = r_tag[k-1];
            end

            assign prod = (EXP_W+EXP_FRAC)'(e_in) * (EXP_W+EXP_FRAC)'(C);
            assign n_e  = m_in[k] ? prod[EXP_W+EXP_FRAC-1:EXP_FRAC] : e_in;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_tag[k].vld <= 1'b0;
                end else if (i_en) begin
                    r_e[k]   <= n_e;
                    r_m[k]   <= m_in;
                    r_tag[k] <= tag_in;
                end
            end
        end
    endgenerate

    assign o_e   = r_e[ARG_W-1];
    assign o_tag = r_tag[ARG_W-1];

endmodule

[sv/afu_div.sv]
`timescale 1ns / 1ps
module afu_div #(
    parameter int FRAC_BITS = 12
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic [afu_pkg::EXP_W:0]     i_num,
    input  logic [afu_pkg::EXP_W:0]     i_den,
    input  afu_pkg::t_tag               i_tag,
    output logic [FRAC_BITS+1:0]        o_q,
    output afu_pkg::t_tag               o_tag
);
    import afu_pkg::*;

    // floor(num * 2^(F+1) / den), num <= den: one quotient bit per stage
    localparam int QW = FRAC_BITS + 2;
    localparam int DW = EXP_W + 1;
    localparam int RW = DW + 1;

    logic [RW-1:0] r_rem [QW];
    logic [DW-1:0] r_den [QW];
    logic [QW-1:0] r_q   [QW];
    t_tag          r_tag [QW];

    genvar j;
    generate
        for (j = 0; j < QW; j++) begin : g_stage
            logic [RW-1:0] rem_in;
            logic [DW-1:0] den_in;
            logic [QW-1:0] q_in;
            t_tag          tag_in;
            logic          ge;
            logic [RW-1:0] rem_sub;

            if (j == 0) begin : g_first
                assign rem_in = RW'(i_num);
                assign den_in = i_den;
                assign q_in   = '0;
                assign tag_in = i_tag;
            end else begin : g_next
                assign rem_in = r_rem[j-1];
                assign den_in = r_den[j-1];
                assign q_in   = r_q[j-1];
                assign tag_in = r_tag[j-1];
            end

            assign ge      = rem_in >= RW'(den_in);
            assign rem_sub = ge ? rem_in - RW'(den_in) : rem_in;

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_tag[j].vld <= 1'b0;
                end else if (i_en) begin
                    r_rem[j] <= {rem_sub[RW-2:0], 1'b0};
                    r_den[j] <= den_in;
                    r_q[j]   <= {q_in[QW-2:0], ge};
                    r_tag[j] <= tag_in;
                end
            end
        end
    endgenerate

    assign o_q   = r_q[QW-1];
    assign o_tag = r_tag[QW-1];

endmodule

[sv/activation_function_unit.sv]
`timescale 1ns / 1ps
// Activation function unit: sigmoid, tanh, linear, relu and step on signed
// fixed-point values with FRAC_BITS fraction bits, forward or derivative.
//
// Input channel: i_valid, o_stall, i_operation, i_value_in. An item is taken
// at a rising edge with i_valid high and o_stall low.
// Output channel: o_valid, i_stall, o_value_out. An item leaves at a rising
// edge with o_valid high and i_stall low.
// Configuration: i_cfg_wr_en writes i_cfg_wr_data into the activation
// register; the register value is captured with each item as it enters.
//
// Throughput: one item per cycle while the receiver does not stall. The
// pipeline has FRAC_BITS + 22 register stages (input register, setup stage,
// 17 exponent stages, FRAC_BITS+2 divider stages, output register).
// Every item takes the full path, so results keep their order.
//
// Reset (i_rst_n low, synchronous) empties the pipeline and sets the
// activation to sigmoid. When the receiver stalls with a result waiting,
// the whole pipeline holds and o_stall rises in the same cycle; nothing is
// dropped or repeated.
module activation_function_unit #(
    parameter int FRAC_BITS = 12
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_wr_en,
    input  logic [2:0]         i_cfg_wr_data,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic               i_operation,
    input  logic signed [15:0] i_value_in,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [15:0] o_value_out
);
    import afu_pkg::*;

    localparam int QW = FRAC_BITS + 2;
    localparam logic signed [PROD_W-1:0] ONE_W  = PROD_W'(1) << FRAC_BITS;
    localparam logic signed [PROD_W-1:0] HALF_W = PROD_W'(1) << (FRAC_BITS - 1);

    // Global advance: the whole pipeline moves unless a result is held
    logic en;
    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    // Activation register
    logic [2:0] r_kind;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kind <= KIND_SIGMOID;
        end else if (i_cfg_wr_en) begin
            r_kind <= i_cfg_wr_data;
        end
    end

    // Stage 0: register the item together with the activation it uses
    logic               r0_vld;
    logic               r0_op;
    logic [2:0]         r0_kind;
    logic signed [15:0] r0_x;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_vld <= 1'b0;
        end else if (en) begin
            r0_vld <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r0_op   <= i_operation;
            r0_kind <= r_kind;
            r0_x    <= i_value_in;
        end
    end

    // Stage 1: exponent argument and every result that needs no exponent
    logic signed [PROD_W-1:0] xw;
    logic signed [PROD_W-1:0] prod;
    logic signed [PROD_W-1:0] rnd;
    logic [ARG_W-1:0]         mag;
    logic [ARG_W-1:0]         n1_m;
    t_tag                     n1_tag;
    logic signed [15:0]       simple;
    logic                     pos;

    assign xw  = PROD_W'(r0_x);
    assign pos = r0_x > 16'sd0;
    assign mag = r0_x[15] ? ARG_W'(-xw) : ARG_W'(xw);

    always_comb begin
        if (r0_kind == KIND_TANH) begin
            prod = ONE_W * ONE_W - xw * xw;
        end else begin
            prod = xw * (ONE_W - xw);
        end
        // floor((p + ONE/2) / ONE)
        rnd = (prod + HALF_W) >>> FRAC_BITS;
    end

    always_comb begin
        case (r0_kind) inside
            KIND_SIGMOID, KIND_TANH: simple = sat16(rnd);
            KIND_LINEAR: simple = (r0_op == OP_DERIV) ? sat16(ONE_W) : r0_x;
            KIND_RELU: begin
                if (r0_op == OP_DERIV) begin
                    simple = pos ? sat16(ONE_W) : 16'sd0;
                end else begin
                    simple = pos ? r0_x : 16'sd0;
                end
            end
            KIND_STEP: begin
                simple = (r0_op == OP_FORWARD && pos) ? sat16(ONE_W) : 16'sd0;
            end
            default: simple = 16'sd0;
        endcase
    end

    always_comb begin
        n1_tag.vld     = r0_vld;
        n1_tag.use_exp = (r0_op == OP_FORWARD)
                         && (r0_kind == KIND_SIGMOID || r0_kind == KIND_TANH);
        n1_tag.is_tanh = r0_kind == KIND_TANH;
        n1_tag.neg     = r0_x[15];
        n1_tag.simple  = simple;
        // tanh uses e^-2|x|
        n1_m           = (r0_kind == KIND_TANH) ? {mag[ARG_W-2:0], 1'b0} : mag;
    end

    t_tag             r1_tag;
    logic [ARG_W-1:0] r1_m;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag.vld <= 1'b0;
        end else if (en) begin
            r1_tag <= n1_tag;
            r1_m   <= n1_m;
        end
    end

    // Exponent pipeline: E = e^-m in Q0.32
    logic [EXP_W-1:0] ex_e;
    t_tag             ex_tag;

    afu_exp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_exp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_m     (r1_m),
        .i_tag   (r1_tag),
        .o_e     (ex_e),
        .o_tag   (ex_tag)
    );

    // Dividend and divisor: sigmoid 1/(1+E) or E/(1+E), tanh (1-E)/(1+E)
    localparam logic [EXP_W:0] ONE_E = (EXP_W + 1)'(1) << EXP_FRAC;
    logic [EXP_W:0] num;
    logic [EXP_W:0] den;

    always_comb begin
        den = ONE_E + (EXP_W + 1)'(ex_e);
        if (ex_tag.is_tanh) begin
            num = ONE_E - (EXP_W + 1)'(ex_e);
        end else if (ex_tag.neg) begin
            num = (EXP_W + 1)'(ex_e);
        end else begin
            num = ONE_E;
        end
    end

    logic [QW-1:0] dv_q;
    t_tag          dv_tag;

    afu_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_num   (num),
        .i_den   (den),
        .i_tag   (ex_tag),
        .o_q     (dv_q),
        .o_tag   (dv_tag)
    );

    // Final stage: halve rounding half up, sign for tanh, pick the result
    logic [QW-1:0]            half_q;
    logic signed [PROD_W-1:0] mag_w;
    logic signed [PROD_W-1:0] fwd_w;
    logic signed [15:0]       result;

    assign half_q = QW'((QW + 1)'(dv_q) + (QW + 1)'(1) >> 1);
    assign mag_w  = PROD_W'(half_q);
    assign fwd_w  = (dv_tag.is_tanh && dv_tag.neg) ? -mag_w : mag_w;
    assign result = dv_tag.use_exp ? sat16(fwd_w) : dv_tag.simple;

    logic               r_out_valid;
    logic signed [15:0] r_out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= dv_tag.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_value <= result;
        end
    end

    assign o_valid     = r_out_valid;
    assign o_value_out = r_out_value;

    // Quotient of the divider never exceeds 2^(F+1) since num <= den
    a_quot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_tag.vld && dv_tag.use_exp |-> dv_q <= (QW'(1) << (FRAC_BITS + 1)))
        else $error("divider quotient out of range");

    // Forward sigmoid never gives a negative value
    a_sig_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dv_tag.vld && dv_tag.use_exp && !dv_tag.is_tanh |-> !result[15])
        else $error("negative sigmoid result");

    // Input is held back only while a result waits on a stalled receiver
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid && i_stall)
        else $error("input stalled without output backpressure");

    // A held pipeline keeps the item waiting at the last divider stage
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> dv_tag.vld == $past(dv_tag.vld))
        else $error("pipeline moved while stalled");

endmodule
